// File: hw/rtl/lph_pkg.sv
// ----------------------------------------------------------------------------
// lph_pkg: shared types and constants of the linear probe hash table
// Operation and result codes, controller command and datapath status bundles.
// ----------------------------------------------------------------------------
package lph_pkg;

	// APB register map
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 2;
	localparam logic [APB_ADDR_W-1:0] ADDR_BUCKET_COUNT = '0;

	// reset value of the bucket_count register
	localparam int BUCKET_COUNT_RESET = 11;

	// operation codes
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_FIND   = 2'd1,
		OP_ERASE  = 2'd2
	} op_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_EXISTED   = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_ERASED    = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	// commands from controller to datapath
	typedef struct packed {
		logic    clr_step;    // write one empty entry of the clearing pass
		logic    accept;      // take the input transfer, start hashing the key
		logic    probe_init;  // probe position = home bucket
		logic    rd_pos;      // read entry at probe position
		logic    probe_next;  // advance probe position
		logic    wr_ins;      // store the key at probe position
		logic    er_init;     // empty probe position, open the hole there
		logic    er_read;     // step point forward and read it
		logic    er_div;      // capture entry at point, hash its key
		logic    er_keep;     // entry at point stays where it is
		logic    wr_hole;     // move captured entry into the hole
		logic    wr_point;    // empty point, hole follows it
		logic    set_code;    // record result code
		status_t code;
		logic    res_load;    // load the result register
	} lph_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic clr_last;
		logic div_busy;
		logic op_insert;
		logic op_find;
		logic op_erase;
		logic ent_used;
		logic key_match;
		logic probe_last;
		logic er_end;
		logic stays;
		logic out_busy;
	} lph_sts_t;

endpackage

// File: hw/rtl/lph_ram.sv
// ----------------------------------------------------------------------------
// lph_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module lph_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/lph_div.sv
// ----------------------------------------------------------------------------
// lph_div: serial remainder unit
// Restoring division, one dividend bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module lph_div #(
	parameter int KEY_WIDTH = 31,
	parameter int IDX_W = 10,
	localparam int CW = $clog2(KEY_WIDTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [KEY_WIDTH-1:0] dividend,
	input  logic [IDX_W:0]       divisor,
	output logic                 busy,
	output logic [IDX_W-1:0]     remainder
);

	logic [CW-1:0]        cnt_q;
	logic [IDX_W-1:0]     rem_q;
	logic [KEY_WIDTH-1:0] shf_q;
	logic [IDX_W:0]       trial;
	logic [IDX_W:0]       diff;
	logic [IDX_W-1:0]     rem_nx;

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(KEY_WIDTH);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign busy = (cnt_q != '0);

	// trial subtract; partial remainder stays below the divisor
	always_comb begin
		trial  = {rem_q, shf_q[KEY_WIDTH-1]};
		diff   = trial - divisor;
		rem_nx = (trial >= divisor) ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			shf_q <= dividend;
		end else if (busy) begin
			rem_q <= rem_nx;
			shf_q <= {shf_q[KEY_WIDTH-2:0], 1'b0};
		end
	end

	assign remainder = rem_q;

endmodule

// File: hw/rtl/lph_dp.sv
// ----------------------------------------------------------------------------
// lph_dp: hash table datapath
// Bucket RAM, remainder unit, probe and shift registers, result register.
// ----------------------------------------------------------------------------
module lph_dp import lph_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH = 31,
	localparam int IDX_W = $clog2(TABLE_DEPTH),
	localparam int CNT_W = IDX_W + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CNT_W-1:0]     bucket_count,
	input  logic [1:0]           op,
	input  logic [KEY_WIDTH-1:0] key,
	input  lph_cmd_t             cmd,
	output lph_sts_t             sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic [IDX_W-1:0]     bucket_index,
	output logic [IDX_W-1:0]     moved_count
);

	localparam int EW = KEY_WIDTH + 1;

	logic [CNT_W-1:0]     divisor;
	logic [1:0]           op_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [KEY_WIDTH-1:0] mv_key_q;
	logic [IDX_W-1:0]     pos_q;
	logic [IDX_W-1:0]     hole_q;
	logic [IDX_W-1:0]     point_q;
	logic [IDX_W-1:0]     moved_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     clr_q;
	status_t              code_q;
	logic                 out_valid_q;
	logic [2:0]           status_q;
	logic [IDX_W-1:0]     index_q;
	logic [IDX_W-1:0]     mcount_q;

	logic [CNT_W-1:0]     pos_inc;
	logic [CNT_W-1:0]     point_inc;
	logic [IDX_W-1:0]     pos_nx;
	logic [IDX_W-1:0]     point_nx;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [EW-1:0]        ram_wdata;
	logic                 ram_re;
	logic [IDX_W-1:0]     ram_raddr;
	logic [EW-1:0]        ram_rdata;

	logic                 div_start;
	logic [KEY_WIDTH-1:0] div_dividend;
	logic                 div_busy;
	logic [IDX_W-1:0]     home;

	// effective divisor: zero acts as one, saturate at table depth
	always_comb begin
		priority if (bucket_count == '0) begin
			divisor = CNT_W'(1);
		end else if (bucket_count > CNT_W'(TABLE_DEPTH)) begin
			divisor = CNT_W'(TABLE_DEPTH);
		end else begin
			divisor = bucket_count;
		end
	end

	// circular successors of probe position and erase point
	always_comb begin
		pos_inc   = {1'b0, pos_q} + 1'b1;
		point_inc = {1'b0, point_q} + 1'b1;
		pos_nx    = (pos_inc == divisor) ? '0 : pos_inc[IDX_W-1:0];
		point_nx  = (point_inc == divisor) ? '0 : point_inc[IDX_W-1:0];
	end

	// bucket RAM write port
	always_comb begin
		ram_we    = 1'b1;
		ram_waddr = pos_q;
		ram_wdata = {1'b0, key_q};
		priority if (cmd.clr_step) begin
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (cmd.wr_ins) begin
			ram_wdata = {1'b1, key_q};
		end else if (cmd.er_init) begin
			ram_wdata = {1'b0, key_q};
		end else if (cmd.wr_hole) begin
			ram_waddr = hole_q;
			ram_wdata = {1'b1, mv_key_q};
		end else if (cmd.wr_point) begin
			ram_waddr = point_q;
			ram_wdata = {1'b0, mv_key_q};
		end else begin
			ram_we = 1'b0;
		end
	end

	// bucket RAM read port
	assign ram_re    = cmd.rd_pos | cmd.er_read;
	assign ram_raddr = cmd.er_read ? point_nx : pos_q;

	lph_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// remainder unit: input key on accept, stored key during erase
	assign div_start    = cmd.accept | cmd.er_div;
	assign div_dividend = cmd.er_div ? ram_rdata[KEY_WIDTH-1:0] : key;

	lph_div #(
		.KEY_WIDTH (KEY_WIDTH),
		.IDX_W     (IDX_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (divisor),
		.busy      (div_busy),
		.remainder (home)
	);

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// operation, probe and erase registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= op;
			key_q <= key;
		end
		if (cmd.probe_init) begin
			pos_q <= home;
		end else if (cmd.probe_next) begin
			pos_q <= pos_nx;
		end
		if (cmd.probe_init) begin
			cnt_q <= '0;
		end else if (cmd.er_init) begin
			cnt_q <= CNT_W'(1);
		end else if (cmd.probe_next || cmd.er_keep || cmd.wr_point) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.er_init) begin
			hole_q  <= pos_q;
			point_q <= pos_q;
			moved_q <= '0;
		end else if (cmd.er_read) begin
			point_q <= point_nx;
		end else if (cmd.wr_point) begin
			hole_q  <= point_q;
			moved_q <= moved_q + 1'b1;
		end
		if (cmd.er_div) begin
			mv_key_q <= ram_rdata[KEY_WIDTH-1:0];
		end
		if (cmd.set_code) begin
			code_q <= cmd.code;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q <= code_q;
			index_q  <= (code_q == ST_INSERTED || code_q == ST_FOUND) ? pos_q : '0;
			mcount_q <= (code_q == ST_ERASED) ? moved_q : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign bucket_index = index_q;
	assign moved_count  = mcount_q;

	// status to controller
	always_comb begin
		sts.clr_last   = (clr_q == IDX_W'(TABLE_DEPTH - 1));
		sts.div_busy   = div_busy;
		sts.op_insert  = (op_q == OP_INSERT);
		sts.op_find    = (op_q == OP_FIND);
		sts.op_erase   = (op_q == OP_ERASE);
		sts.ent_used   = ram_rdata[KEY_WIDTH];
		sts.key_match  = (ram_rdata[KEY_WIDTH-1:0] == key_q);
		sts.probe_last = ((cnt_q + 1'b1) == divisor);
		sts.er_end     = (cnt_q == divisor);
		// entry stays if its home lies in the circular range (hole, point]
		if (hole_q < point_q) begin
			sts.stays = (home > hole_q) && (home <= point_q);
		end else begin
			sts.stays = (home > hole_q) || (home <= point_q);
		end
		sts.out_busy   = out_valid_q && !out_ready;
	end

	// no table write while a key is being hashed
	assert property (@(posedge clk) disable iff (!arst_n) ram_we |-> !div_busy)
		else $error("bucket write during remainder computation");

	// probe reads stay inside the buckets in use
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_pos |-> ({1'b0, pos_q} < divisor))
		else $error("probe position beyond divisor");

	// a pending result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

endmodule

// File: hw/rtl/lph_ctrl.sv
// ----------------------------------------------------------------------------
// lph_ctrl: hash table controller
// Sequences clearing, hashing, probing, insert, and backward-shift erase.
// ----------------------------------------------------------------------------
module lph_ctrl import lph_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  lph_sts_t sts,
	output lph_cmd_t cmd
);

	typedef enum logic [12:0] {
		S_CLEAR = 13'b0000000000001,
		S_IDLE  = 13'b0000000000010,
		S_DIV   = 13'b0000000000100,
		S_RD    = 13'b0000000001000,
		S_PRB   = 13'b0000000010000,
		S_INS   = 13'b0000000100000,
		S_EWR   = 13'b0000001000000,
		S_ESTEP = 13'b0000010000000,
		S_ERD   = 13'b0000100000000,
		S_EDIV  = 13'b0001000000000,
		S_EMV1  = 13'b0010000000000,
		S_EMV2  = 13'b0100000000000,
		S_FIN   = 13'b1000000000000
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		cmd.code = ST_NOT_FOUND;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nx   = S_DIV;
				end
			end
			S_DIV: begin
				if (!sts.div_busy) begin
					cmd.probe_init = 1'b1;
					state_nx       = S_RD;
				end
			end
			S_RD: begin
				cmd.rd_pos = 1'b1;
				state_nx   = S_PRB;
			end
			// key, empty bucket or the last bucket in use ends the probe
			S_PRB: begin
				if (!sts.ent_used || sts.key_match) begin
					priority if (sts.op_insert && !sts.ent_used) begin
						state_nx = S_INS;
					end else if (sts.op_insert) begin
						cmd.set_code = 1'b1;
						cmd.code     = ST_EXISTED;
						state_nx     = S_FIN;
					end else if (sts.op_find && sts.ent_used) begin
						cmd.set_code = 1'b1;
						cmd.code     = ST_FOUND;
						state_nx     = S_FIN;
					end else if (sts.op_erase && sts.ent_used) begin
						state_nx = S_EWR;
					end else begin
						cmd.set_code = 1'b1;
						cmd.code     = ST_NOT_FOUND;
						state_nx     = S_FIN;
					end
				end else if (sts.probe_last) begin
					cmd.set_code = 1'b1;
					cmd.code     = sts.op_insert ? ST_FULL : ST_NOT_FOUND;
					state_nx     = S_FIN;
				end else begin
					cmd.probe_next = 1'b1;
					state_nx       = S_RD;
				end
			end
			S_INS: begin
				cmd.wr_ins   = 1'b1;
				cmd.set_code = 1'b1;
				cmd.code     = ST_INSERTED;
				state_nx     = S_FIN;
			end
			S_EWR: begin
				cmd.er_init  = 1'b1;
				cmd.set_code = 1'b1;
				cmd.code     = ST_ERASED;
				state_nx     = S_ESTEP;
			end
			// walk the cluster after the hole
			S_ESTEP: begin
				if (sts.er_end) begin
					state_nx = S_FIN;
				end else begin
					cmd.er_read = 1'b1;
					state_nx    = S_ERD;
				end
			end
			S_ERD: begin
				if (!sts.ent_used) begin
					state_nx = S_FIN;
				end else begin
					cmd.er_div = 1'b1;
					state_nx   = S_EDIV;
				end
			end
			S_EDIV: begin
				if (!sts.div_busy) begin
					if (sts.stays) begin
						cmd.er_keep = 1'b1;
						state_nx    = S_ESTEP;
					end else begin
						state_nx = S_EMV1;
					end
				end
			end
			S_EMV1: begin
				cmd.wr_hole = 1'b1;
				state_nx    = S_EMV2;
			end
			S_EMV2: begin
				cmd.wr_point = 1'b1;
				state_nx     = S_ESTEP;
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.res_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// one operation at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second transfer accepted during an operation");

	// no result while a remainder is still being computed
	assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_busy |-> !cmd.res_load)
		else $error("result issued with remainder pending");

endmodule

// File: hw/rtl/linear_probe_hash_table_top.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top: open-addressed hash table with linear probing
// One operation at a time; hashing a key holds the controller in the serial
// remainder unit, a probe step reads and checks a bucket, and an erase cluster
// member is read and hashed, then moved into the hole, emptying its bucket, if
// it may not stay. A new insert adds a bucket write. After reset a clearing
// pass empties every bucket while in_ready stays low; bucket_count resets to
// 11 and takes APB writes throughout.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top import lph_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH = 31,
	localparam int IDX_W = $clog2(TABLE_DEPTH),
	localparam int CNT_W = IDX_W + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// operation input
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            op,
	input  logic [KEY_WIDTH-1:0]  key,
	// result output
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            status,
	output logic [IDX_W-1:0]      bucket_index,
	output logic [IDX_W-1:0]      moved_count
);

	logic [CNT_W-1:0] bucket_count_q;
	logic             cfg_wr;
	lph_cmd_t         cmd;
	lph_sts_t         sts;

	// register write on the APB access transfer
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_BUCKET_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= CNT_W'(BUCKET_COUNT_RESET);
		end else if (cfg_wr) begin
			bucket_count_q <= pwdata[CNT_W-1:0];
		end
	end

	// register read
	assign prdata = (paddr == ADDR_BUCKET_COUNT) ?
		{{(APB_DATA_W - CNT_W){1'b0}}, bucket_count_q} : '0;

	lph_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lph_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_WIDTH   (KEY_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.bucket_count (bucket_count_q),
		.op           (op),
		.key          (key),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.bucket_index (bucket_index),
		.moved_count  (moved_count)
	);

endmodule
